>>> hdl/sip4_pkg.sv
// Shared types, mode codes and rounding averages for the 4x4 sub-block intra predictor.
package sip4_pkg;

    localparam int PixW     = 8;
    localparam int AboveN   = 8;
    localparam int LeftN    = 4;
    localparam int BlkN     = 4;
    localparam int RowW     = BlkN * PixW;
    localparam int InDataW  = PixW + AboveN * PixW + LeftN * PixW;
    localparam int OutDataW = BlkN * RowW;

    typedef enum logic [3:0] {
        MODE_DC = 4'd0,
        MODE_TM = 4'd1,
        MODE_VE = 4'd2,
        MODE_HE = 4'd3,
        MODE_LD = 4'd4,
        MODE_RD = 4'd5,
        MODE_VR = 4'd6,
        MODE_VL = 4'd7,
        MODE_HD = 4'd8,
        MODE_HU = 4'd9
    } mode_t;

    typedef logic [PixW-1:0] pix_t;

    // (a + b + 1) >> 1
    function automatic pix_t av2(input pix_t a, input pix_t b);
        logic [PixW:0] s;
        s = {1'b0, a} + {1'b0, b} + {{PixW{1'b0}}, 1'b1};
        return s[PixW:1];
    endfunction

    // (a + 2b + c + 2) >> 2
    function automatic pix_t av3(input pix_t a, input pix_t b, input pix_t c);
        logic [PixW+1:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + {{PixW{1'b0}}, 2'b10};
        return s[PixW+1:2];
    endfunction

endpackage

>>> hdl/sip4_pred.sv
// Combinational 4x4 prediction for the ten sub-block modes.
module sip4_pred
    import sip4_pkg::*;
(
    input  logic [3:0]          op,
    input  pix_t                corner,
    input  logic [AboveN*PixW-1:0] above_row,
    input  logic [LeftN*PixW-1:0]  left_col,
    output logic [OutDataW-1:0] rows
);

    pix_t              a [AboveN+1];
    pix_t              l [LeftN];
    pix_t              e [13];
    pix_t              b [BlkN][BlkN];
    logic [PixW+2:0]   dc_sum;
    logic signed [PixW+1:0] tm_v;

    always_comb begin
        for (int c = 0; c < AboveN; c++) begin
            a[c] = above_row[PixW*c +: PixW];
        end
        a[AboveN] = a[AboveN-1];
        for (int r = 0; r < LeftN; r++) begin
            l[r] = left_col[PixW*r +: PixW];
        end
        // edge line: left bottom-up, corner, above row
        for (int r = 0; r < LeftN; r++) begin
            e[r] = l[LeftN-1-r];
        end
        e[4] = corner;
        for (int c = 0; c < AboveN; c++) begin
            e[5+c] = a[c];
        end

        dc_sum = 11'd4;
        for (int c = 0; c < BlkN; c++) begin
            dc_sum = dc_sum + {3'b000, a[c]} + {3'b000, l[c]};
        end

        tm_v = '0;
        for (int r = 0; r < BlkN; r++) begin
            for (int c = 0; c < BlkN; c++) begin
                b[r][c] = '0;
            end
        end

        case (op)
            MODE_DC: begin
                for (int r = 0; r < BlkN; r++) begin
                    for (int c = 0; c < BlkN; c++) begin
                        b[r][c] = dc_sum[PixW+2:3];
                    end
                end
            end
            MODE_TM: begin
                for (int r = 0; r < BlkN; r++) begin
                    for (int c = 0; c < BlkN; c++) begin
                        tm_v = signed'({2'b00, l[r]}) + signed'({2'b00, a[c]})
                             - signed'({2'b00, corner});
                        if (tm_v < 0) begin
                            b[r][c] = '0;
                        end else if (tm_v > 10'sd255) begin
                            b[r][c] = '1;
                        end else begin
                            b[r][c] = tm_v[PixW-1:0];
                        end
                    end
                end
            end
            MODE_VE: begin
                for (int c = 0; c < BlkN; c++) begin
                    for (int r = 0; r < BlkN; r++) begin
                        b[r][c] = av3(e[4+c], e[5+c], e[6+c]);
                    end
                end
            end
            MODE_HE: begin
                for (int c = 0; c < BlkN; c++) begin
                    b[0][c] = av3(corner, l[0], l[1]);
                    b[1][c] = av3(l[0], l[1], l[2]);
                    b[2][c] = av3(l[1], l[2], l[3]);
                    b[3][c] = av3(l[2], l[3], l[3]);
                end
            end
            MODE_LD: begin
                for (int r = 0; r < BlkN; r++) begin
                    for (int c = 0; c < BlkN; c++) begin
                        b[r][c] = av3(a[r+c], a[r+c+1], a[r+c+2]);
                    end
                end
            end
            MODE_RD: begin
                for (int r = 0; r < BlkN; r++) begin
                    for (int c = 0; c < BlkN; c++) begin
                        b[r][c] = av3(e[3-r+c], e[4-r+c], e[5-r+c]);
                    end
                end
            end
            MODE_VR: begin
                b[3][0] = av3(e[1], e[2], e[3]);
                b[2][0] = av3(e[2], e[3], e[4]);
                b[3][1] = av3(e[3], e[4], e[5]);
                b[1][0] = b[3][1];
                b[2][1] = av2(e[4], e[5]);
                b[0][0] = b[2][1];
                b[3][2] = av3(e[4], e[5], e[6]);
                b[1][1] = b[3][2];
                b[2][2] = av2(e[5], e[6]);
                b[0][1] = b[2][2];
                b[3][3] = av3(e[5], e[6], e[7]);
                b[1][2] = b[3][3];
                b[2][3] = av2(e[6], e[7]);
                b[0][2] = b[2][3];
                b[1][3] = av3(e[6], e[7], e[8]);
                b[0][3] = av2(e[7], e[8]);
            end
            MODE_VL: begin
                b[0][0] = av2(a[0], a[1]);
                b[1][0] = av3(a[0], a[1], a[2]);
                b[2][0] = av2(a[1], a[2]);
                b[0][1] = b[2][0];
                b[1][1] = av3(a[1], a[2], a[3]);
                b[3][0] = b[1][1];
                b[2][1] = av2(a[2], a[3]);
                b[0][2] = b[2][1];
                b[3][1] = av3(a[2], a[3], a[4]);
                b[1][2] = b[3][1];
                b[2][2] = av2(a[3], a[4]);
                b[0][3] = b[2][2];
                b[3][2] = av3(a[3], a[4], a[5]);
                b[1][3] = b[3][2];
                b[2][3] = av3(a[4], a[5], a[6]);
                b[3][3] = av3(a[5], a[6], a[7]);
            end
            MODE_HD: begin
                b[3][0] = av2(e[0], e[1]);
                b[3][1] = av3(e[0], e[1], e[2]);
                b[2][0] = av2(e[1], e[2]);
                b[3][2] = b[2][0];
                b[2][1] = av3(e[1], e[2], e[3]);
                b[3][3] = b[2][1];
                b[2][2] = av2(e[2], e[3]);
                b[1][0] = b[2][2];
                b[2][3] = av3(e[2], e[3], e[4]);
                b[1][1] = b[2][3];
                b[1][2] = av2(e[3], e[4]);
                b[0][0] = b[1][2];
                b[1][3] = av3(e[3], e[4], e[5]);
                b[0][1] = b[1][3];
                b[0][2] = av3(e[4], e[5], e[6]);
                b[0][3] = av3(e[5], e[6], e[7]);
            end
            MODE_HU: begin
                b[0][0] = av2(l[0], l[1]);
                b[0][1] = av3(l[0], l[1], l[2]);
                b[0][2] = av2(l[1], l[2]);
                b[1][0] = b[0][2];
                b[0][3] = av3(l[1], l[2], l[3]);
                b[1][1] = b[0][3];
                b[1][2] = av2(l[2], l[3]);
                b[2][0] = b[1][2];
                b[1][3] = av3(l[2], l[3], l[3]);
                b[2][1] = b[1][3];
                b[2][2] = l[3];
                b[2][3] = l[3];
                for (int c = 0; c < BlkN; c++) begin
                    b[3][c] = l[3];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int r = 0; r < BlkN; r++) begin
            for (int c = 0; c < BlkN; c++) begin
                rows[RowW*r + PixW*c +: PixW] = b[r][c];
            end
        end
    end

endmodule

>>> hdl/subblock_intra_predictor_4x4.sv
// A word accepted into the input register passes through the result register to m_tvalid.
// Throughput: one word per cycle while m_tready is high; the result register refills in the cycle it is taken.
// The prediction itself is one level of average/clamp logic between the two registers.
// Reset (aresetn low, synchronous) clears both valid flags; data registers are not reset.
// Top level of the 4x4 sub-block intra predictor.
module subblock_intra_predictor_4x4
    import sip4_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // corner[7:0], above_row[71:8], left_col[103:72]
    input  logic [3:0]          s_tuser,   // op[3:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata    // row_zero, row_one, row_two, row_three, 32b each
);

    logic                  s1_valid_reg;
    logic [3:0]            s1_op_reg;
    logic [InDataW-1:0]    s1_data_reg;
    logic                  out_valid_reg;
    logic [OutDataW-1:0]   out_data_reg;
    logic [OutDataW-1:0]   out_data_next;
    logic                  out_load;
    logic                  s1_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_load;
    assign s1_load  = s_tvalid && s_tready;

    sip4_pred u_pred (
        .op        (s1_op_reg),
        .corner    (s1_data_reg[PixW-1:0]),
        .above_row (s1_data_reg[PixW +: AboveN*PixW]),
        .left_col  (s1_data_reg[PixW + AboveN*PixW +: LeftN*PixW]),
        .rows      (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_op_reg   <= s_tuser;
            s1_data_reg <= s_tdata;
        end
        if (out_load && s1_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_load |=> s1_valid_reg)
        else $error("accepted word did not reach input register");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages full and stalled");

    a_s1_moves_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_load) |=> m_tvalid)
        else $error("input register word lost on transfer");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s1_valid_reg))
        else $error("valid flags not cleared by reset");
`endif

endmodule

>>> tb/subblock_intra_predictor_4x4_test.sv
// Testbench for the 4x4 sub-block intra predictor: directed and random stream stimulus, scoreboard check.
`timescale 1ns / 100ps

import sip4_pkg::*;

class intra_scoreboard;
    logic [OutDataW-1:0] predicted_blocks[$];
    int                  fails;

    function new();
        fails = 0;
    endfunction

    static function int mean2(int x, int y);
        return (x + y + 1) >> 1;
    endfunction

    static function int mean3(int x, int y, int z);
        return (x + 2 * y + z + 2) >> 2;
    endfunction

    function logic [OutDataW-1:0] predict_block(logic [3:0] op, logic [7:0] corner,
                                                logic [63:0] above, logic [31:0] left);
        int a[9];
        int l[4];
        int e[13];
        int blk[4][4];
        int s;
        int v;
        int up;
        int dn;
        int k;
        logic [OutDataW-1:0] rows;
        for (int c = 0; c < 8; c++) a[c] = above[8*c +: 8];
        a[8] = a[7];
        for (int r = 0; r < 4; r++) l[r] = left[8*r +: 8];
        for (int r = 0; r < 4; r++) e[r] = l[3-r];
        e[4] = corner;
        for (int c = 0; c < 8; c++) e[5+c] = a[c];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) blk[r][c] = 0;

        case (mode_t'(op))
            MODE_DC: begin
                s = 4;
                for (int c = 0; c < 4; c++) s += a[c] + l[c];
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) blk[r][c] = s >> 3;
            end
            MODE_TM: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) begin
                        v = l[r] + a[c] - int'(corner);
                        blk[r][c] = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                    end
            end
            MODE_VE: begin
                for (int c = 0; c < 4; c++) begin
                    v = mean3(e[4+c], e[5+c], e[6+c]);
                    for (int r = 0; r < 4; r++) blk[r][c] = v;
                end
            end
            MODE_HE: begin
                for (int r = 0; r < 4; r++) begin
                    up = (r == 0) ? int'(corner) : l[r-1];
                    dn = (r == 3) ? l[3] : l[r+1];
                    v = mean3(up, l[r], dn);
                    for (int c = 0; c < 4; c++) blk[r][c] = v;
                end
            end
            MODE_LD: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        blk[r][c] = mean3(a[r+c], a[r+c+1], a[r+c+2]);
            end
            MODE_RD: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) begin
                        k = 4 - r + c;
                        blk[r][c] = mean3(e[k-1], e[k], e[k+1]);
                    end
            end
            MODE_VR: begin
                blk[3][0] = mean3(e[1], e[2], e[3]);
                blk[2][0] = mean3(e[2], e[3], e[4]);
                blk[3][1] = mean3(e[3], e[4], e[5]);
                blk[1][0] = blk[3][1];
                blk[2][1] = mean2(e[4], e[5]);
                blk[0][0] = blk[2][1];
                blk[3][2] = mean3(e[4], e[5], e[6]);
                blk[1][1] = blk[3][2];
                blk[2][2] = mean2(e[5], e[6]);
                blk[0][1] = blk[2][2];
                blk[3][3] = mean3(e[5], e[6], e[7]);
                blk[1][2] = blk[3][3];
                blk[2][3] = mean2(e[6], e[7]);
                blk[0][2] = blk[2][3];
                blk[1][3] = mean3(e[6], e[7], e[8]);
                blk[0][3] = mean2(e[7], e[8]);
            end
            MODE_VL: begin
                blk[0][0] = mean2(a[0], a[1]);
                blk[1][0] = mean3(a[0], a[1], a[2]);
                blk[2][0] = mean2(a[1], a[2]);
                blk[0][1] = blk[2][0];
                blk[1][1] = mean3(a[1], a[2], a[3]);
                blk[3][0] = blk[1][1];
                blk[2][1] = mean2(a[2], a[3]);
                blk[0][2] = blk[2][1];
                blk[3][1] = mean3(a[2], a[3], a[4]);
                blk[1][2] = blk[3][1];
                blk[2][2] = mean2(a[3], a[4]);
                blk[0][3] = blk[2][2];
                blk[3][2] = mean3(a[3], a[4], a[5]);
                blk[1][3] = blk[3][2];
                blk[2][3] = mean3(a[4], a[5], a[6]);
                blk[3][3] = mean3(a[5], a[6], a[7]);
            end
            MODE_HD: begin
                blk[3][0] = mean2(e[0], e[1]);
                blk[3][1] = mean3(e[0], e[1], e[2]);
                blk[2][0] = mean2(e[1], e[2]);
                blk[3][2] = blk[2][0];
                blk[2][1] = mean3(e[1], e[2], e[3]);
                blk[3][3] = blk[2][1];
                blk[2][2] = mean2(e[2], e[3]);
                blk[1][0] = blk[2][2];
                blk[2][3] = mean3(e[2], e[3], e[4]);
                blk[1][1] = blk[2][3];
                blk[1][2] = mean2(e[3], e[4]);
                blk[0][0] = blk[1][2];
                blk[1][3] = mean3(e[3], e[4], e[5]);
                blk[0][1] = blk[1][3];
                blk[0][2] = mean3(e[4], e[5], e[6]);
                blk[0][3] = mean3(e[5], e[6], e[7]);
            end
            MODE_HU: begin
                blk[0][0] = mean2(l[0], l[1]);
                blk[0][1] = mean3(l[0], l[1], l[2]);
                blk[0][2] = mean2(l[1], l[2]);
                blk[1][0] = blk[0][2];
                blk[0][3] = mean3(l[1], l[2], l[3]);
                blk[1][1] = blk[0][3];
                blk[1][2] = mean2(l[2], l[3]);
                blk[2][0] = blk[1][2];
                blk[1][3] = mean3(l[2], l[3], l[3]);
                blk[2][1] = blk[1][3];
                blk[2][2] = l[3];
                blk[2][3] = l[3];
                for (int c = 0; c < 4; c++) blk[3][c] = l[3];
            end
            default: ;
        endcase

        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) rows[RowW*r + PixW*c +: PixW] = blk[r][c][7:0];
        return rows;
    endfunction

    function void note_block(logic [3:0] op, logic [InDataW-1:0] data);
        predicted_blocks.push_back(predict_block(op, data[7:0], data[71:8], data[103:72]));
    endfunction

    function void check_rows(logic [OutDataW-1:0] got);
        string               names[4];
        logic [OutDataW-1:0] want;
        names = '{"row_zero", "row_one", "row_two", "row_three"};
        if (predicted_blocks.size() == 0) begin
            $error("unexpected word: m_tdata %h", got);
            fails++;
            return;
        end
        want = predicted_blocks.pop_front();
        for (int r = 0; r < 4; r++) begin
            if (got[RowW*r +: RowW] !== want[RowW*r +: RowW]) begin
                $error("%s expected %h actual %h", names[r],
                       want[RowW*r +: RowW], got[RowW*r +: RowW]);
                fails++;
            end
        end
    endfunction
endclass

module subblock_intra_predictor_4x4_test;
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;   // corner[7:0], above_row[71:8], left_col[103:72]
    logic [3:0]          s_tuser  = '0;   // op[3:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;        // row_zero, row_one, row_two, row_three

    intra_scoreboard sb = new();
    int              rx_tick = 0;
    int              rx_mode = 0;

    subblock_intra_predictor_4x4 u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_rows(m_tdata);
        if (aresetn && s_tvalid && s_tready) sb.note_block(s_tuser, s_tdata);
    end

    // receiver: switches between free-running, random, sparse and periodic stall patterns
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_tick % 16) >= 11);
        endcase
    end

    task automatic send_block(logic [3:0] op, logic [7:0] corner,
                              logic [63:0] above, logic [31:0] left);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {left, above, corner};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_pixel(int bias);
        case ($urandom_range(0, bias))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random(int bias);
        logic [3:0]  op;
        logic [63:0] above;
        logic [31:0] left;
        logic [7:0]  corner;
        if ($urandom_range(0, 9) == 0) op = 4'($urandom_range(int'(MODE_HU) + 1, 15));
        else op = 4'($urandom_range(int'(MODE_DC), int'(MODE_HU)));
        for (int i = 0; i < 8; i++) above[8*i +: 8] = pick_pixel(bias);
        for (int i = 0; i < 4; i++) left[8*i +: 8] = pick_pixel(bias);
        corner = pick_pixel(bias);
        send_block(op, corner, above, left);
    endtask

    task automatic run_random(int count, bit no_gaps);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++) begin
                // mostly random pixels, sometimes heavy on 0/255 to push TM clamping
                send_random(($urandom_range(0, 3) == 0) ? 2 : 12);
                sent++;
            end
            gap = no_gaps ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                                : $urandom_range(0, 3));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        mode_t m;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        m = m.first();
        forever begin
            send_block(m, 8'hff, '1, '1);
            if (m == m.last()) break;
            m = m.next();
        end
        send_block(MODE_DC, 8'h00, '0, '0);
        send_block(MODE_TM, 8'hff, '0, '0);
        send_block(MODE_TM, 8'h00, '1, '1);
        send_block(MODE_LD, 8'h00, 64'hff00_0000_0000_0000, '0);
        send_block(MODE_HU, 8'h00, '0, 32'hff00_0000);
        for (int u = int'(MODE_HU) + 1; u < 16; u++)
            send_block(4'(u), 8'($urandom), {$urandom, $urandom}, $urandom);

        run_random(120, 1'b1);
        run_random(580, 1'b0);
        s_tvalid <= 1'b0;

        while (sb.predicted_blocks.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
